// ===== sv/dtrrd_pkg.sv =====
`default_nettype none
package dtrrd_pkg;

  localparam int unsigned RING_ENTRIES = 64;
  localparam int unsigned DEPTH_W      = 16;
  localparam int unsigned RECORD_W     = 64;
  localparam int unsigned THR_W        = 15;
  localparam int unsigned CFG_IDX_W    = 1;

  localparam logic [THR_W-1:0] SUBMERGE_RESET = 15'd100;
  localparam logic [THR_W-1:0] SURFACE_RESET  = 15'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SUBMERGE = 1'b0,
    REG_SURFACE  = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } dump_state_t;

  typedef struct packed {
    logic signed [DEPTH_W-1:0] depth_cm;
    logic [RECORD_W-1:0]       record_word;
  } sample_t;

  typedef struct packed {
    logic signed [DEPTH_W-1:0] out_depth_cm;
    logic [RECORD_W-1:0]       out_record;
    logic                      last_of_dump;
  } dump_item_t;

  typedef struct packed {
    logic signed [DEPTH_W-1:0] depth;
    logic [RECORD_W-1:0]       record;
  } ring_entry_t;

endpackage
`default_nettype wire

// ===== sv/dtrrd_ring.sv =====
`default_nettype none
module dtrrd_ring #(
  parameter int unsigned ENTRIES = dtrrd_pkg::RING_ENTRIES
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(ENTRIES)-1:0] wr_addr,
  input  dtrrd_pkg::ring_entry_t     wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(ENTRIES)-1:0] rd_addr,
  output dtrrd_pkg::ring_entry_t     rd_data
);
  import dtrrd_pkg::*;

  ring_entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/dtrrd_ctrl.sv =====
`default_nettype none
module dtrrd_ctrl #(
  parameter int unsigned ENTRIES = dtrrd_pkg::RING_ENTRIES
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  sample_valid,
  output logic                                  sample_stall,
  input  logic signed [dtrrd_pkg::DEPTH_W-1:0]  sample_depth,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dtrrd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dtrrd_pkg::THR_W-1:0]           cfg_data,
  output logic                                  dump_valid,
  input  logic                                  dump_stall,
  output logic                                  dump_last,
  output logic                                  wr_en,
  output logic [$clog2(ENTRIES)-1:0]            wr_addr,
  output logic                                  rd_en,
  output logic [$clog2(ENTRIES)-1:0]            rd_addr
);
  import dtrrd_pkg::*;

  localparam int unsigned ADDR_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(ENTRIES);

  dump_state_t state, state_next;

  logic [THR_W-1:0]          submerge_thr;
  logic [THR_W-1:0]          surface_thr;
  logic [ADDR_W-1:0]         wp, wp_next;
  logic [CNT_W-1:0]          fill, fill_next;
  logic                      was_sub, was_sub_next;
  logic signed [DEPTH_W-1:0] prev_depth;
  logic [ADDR_W-1:0]         rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0]          remain, remain_next;
  logic                      dump_valid_next;
  logic                      dump_last_next;

  logic                      accept;
  logic                      trigger;
  logic                      slot_free;
  logic [ADDR_W-1:0]         wp_inc;
  logic [CNT_W-1:0]          fill_inc;
  logic [CNT_W-1:0]          wp_ext;
  logic [ADDR_W-1:0]         start;
  logic signed [DEPTH_W-1:0] sub_s;
  logic signed [DEPTH_W-1:0] surf_s;
  logic                      sub_hit;

  assign cfg_ready = 1'b1;
  assign accept    = sample_valid && !sample_stall;
  assign slot_free = !dump_valid || !dump_stall;

  assign sub_s  = {1'b0, submerge_thr};
  assign surf_s = {1'b0, surface_thr};

  assign wp_inc   = (wp == ADDR_LAST) ? '0 : wp + 1'b1;
  assign fill_inc = (fill == CNT_FULL) ? fill : fill + 1'b1;
  assign wp_ext   = CNT_W'(wp_inc);
  assign start    = (wp_ext >= fill_inc) ? ADDR_W'(wp_ext - fill_inc)
                                         : ADDR_W'(wp_ext + CNT_FULL - fill_inc);
  assign sub_hit  = was_sub || (sample_depth >= sub_s);
  assign trigger  = sub_hit && (sample_depth < surf_s) && (prev_depth >= surf_s);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && trigger) begin
          state_next = ST_DUMP;
        end
      end
      ST_DUMP: begin
        if (slot_free && remain == CNT_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    sample_stall = 1'b1;
    rd_en        = 1'b0;
    unique case (state)
      ST_IDLE: sample_stall = 1'b0;
      ST_DUMP: rd_en = slot_free;
      default: sample_stall = 1'b1;
    endcase
  end

  assign wr_en   = accept;
  assign wr_addr = wp;
  assign rd_addr = rd_ptr;

  always_comb begin
    wp_next      = wp;
    fill_next    = fill;
    was_sub_next = was_sub;
    rd_ptr_next  = rd_ptr;
    remain_next  = remain;
    if (accept) begin
      if (trigger) begin
        wp_next      = '0;
        fill_next    = '0;
        was_sub_next = 1'b0;
        rd_ptr_next  = start;
        remain_next  = fill_inc;
      end else begin
        wp_next      = wp_inc;
        fill_next    = fill_inc;
        was_sub_next = sub_hit;
      end
    end else if (rd_en) begin
      rd_ptr_next = (rd_ptr == ADDR_LAST) ? '0 : rd_ptr + 1'b1;
      remain_next = remain - 1'b1;
    end
  end

  always_comb begin
    dump_last_next  = dump_last;
    dump_valid_next = dump_valid && dump_stall;
    if (rd_en) begin
      dump_valid_next = 1'b1;
      dump_last_next  = (remain == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      submerge_thr <= SUBMERGE_RESET;
      surface_thr  <= SURFACE_RESET;
      wp           <= '0;
      fill         <= '0;
      was_sub      <= 1'b0;
      prev_depth   <= '0;
      rd_ptr       <= '0;
      remain       <= '0;
      dump_valid   <= 1'b0;
      dump_last    <= 1'b0;
    end else begin
      state      <= state_next;
      wp         <= wp_next;
      fill       <= fill_next;
      was_sub    <= was_sub_next;
      rd_ptr     <= rd_ptr_next;
      remain     <= remain_next;
      dump_valid <= dump_valid_next;
      dump_last  <= dump_last_next;
      if (accept) begin
        prev_depth <= sample_depth;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_SUBMERGE: submerge_thr <= cfg_data;
          REG_SURFACE:  surface_thr  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/depth_triggered_record_ring_dump_unit.sv =====
`default_nettype none
// Push: a sample is taken whenever no dump is running.
// Dump: taking the triggering sample puts the controller in its dump state, which issues reads;
// entries go valid from the registered read data, one per cycle from the ring's single read port
// unless dump_stall holds; samples stall until every dumped entry (at most RING_ENTRIES) is read.
// Reset (synchronous) empties the ring, clears the flag and previous depth,
// and restores thresholds 100 and 50; ring contents are not cleared.
module depth_triggered_record_ring_dump_unit #(
  parameter int unsigned RING_ENTRIES = dtrrd_pkg::RING_ENTRIES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  dtrrd_pkg::sample_t                sample_data,
  output logic                              dump_valid,
  input  logic                              dump_stall,
  output dtrrd_pkg::dump_item_t             dump_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dtrrd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dtrrd_pkg::THR_W-1:0]       cfg_data
);
  import dtrrd_pkg::*;

  localparam int unsigned ADDR_W = $clog2(RING_ENTRIES);

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              dump_last;
  ring_entry_t       wr_entry;
  ring_entry_t       rd_entry;

  assign wr_entry.depth  = sample_data.depth_cm;
  assign wr_entry.record = sample_data.record_word;

  dtrrd_ctrl #(
    .ENTRIES (RING_ENTRIES)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_depth (sample_data.depth_cm),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .dump_valid   (dump_valid),
    .dump_stall   (dump_stall),
    .dump_last    (dump_last),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr)
  );

  dtrrd_ring #(
    .ENTRIES (RING_ENTRIES)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  assign dump_data.out_depth_cm = rd_entry.depth;
  assign dump_data.out_record   = rd_entry.record;
  assign dump_data.last_of_dump = dump_last;

endmodule
`default_nettype wire
